@@ rtl/udcp_pkg.sv @@
`default_nettype none

package udcp_pkg;

    localparam int LINE_CAPACITY_DEF = 100;

    localparam int STATUS_W = 3;
    localparam int LEVEL_W  = 7;
    localparam int PWM_W    = 10;
    localparam int BYTE_W   = 8;
    localparam int ACCUM_W  = 7;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd50;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 7'd99;
    localparam logic [ACCUM_W-1:0] ACCUM_SAT   = 7'd100;

    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_LOW_L = 8'h6C;
    localparam logic [BYTE_W-1:0] CH_UP_L  = 8'h4C;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_BUTTON = 1'b1;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'd0,
        PH_EQ     = 3'd1,
        PH_WS     = 3'd2,
        PH_SIGN   = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5,
        PH_BADCMD = 3'd6
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE    = 3'd0,
        ST_SET     = 3'd1,
        ST_BADVAL  = 3'd2,
        ST_BADCMD  = 3'd3,
        ST_TOOLONG = 3'd4
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [LEVEL_W-1:0]   level;
        logic [PWM_W-1:0]     pwm_compare;
        logic                 lit;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/udcp_in_if.sv @@
`default_nettype none

interface udcp_in_if;
    import udcp_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/udcp_out_if.sv @@
`default_nettype none

interface udcp_out_if;
    import udcp_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [LEVEL_W-1:0]  level;
    logic [PWM_W-1:0]    pwm_compare;
    logic                lit;

    modport source (output valid, output status, output level, output pwm_compare,
                    output lit, input ready);
    modport sink   (input valid, input status, input level, input pwm_compare,
                    input lit, output ready);
endinterface

`default_nettype wire

@@ rtl/udcp_parser.sv @@
`default_nettype none

module udcp_parser #(
    parameter int LINE_CAPACITY = udcp_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic                        i_op,
    input  wire logic [udcp_pkg::BYTE_W-1:0] i_byte,
    output udcp_pkg::t_result                o_result
);
    import udcp_pkg::*;

    localparam int CW = $clog2(LINE_CAPACITY);
    localparam logic [CW-1:0] COUNT_LAST = CW'(LINE_CAPACITY - 1);

    logic [CW-1:0]      r_count, n_count;
    t_phase             r_phase, n_phase;
    logic [ACCUM_W-1:0] r_accum, n_accum;
    logic               r_neg, n_neg;
    logic               r_saw, n_saw;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic               r_lit, n_lit;

    logic               w_is_digit;
    logic               w_is_ws;
    logic [PWM_W-1:0]   w_acc_sum;
    logic [ACCUM_W-1:0] w_acc_next;
    t_status            w_status;

    always_comb begin
        w_is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        w_is_ws    = (i_byte == CH_SPACE) || (i_byte == CH_TAB) ||
                     (i_byte == CH_VT) || (i_byte == CH_FF);
        w_acc_sum  = {r_accum, 3'b000} + {2'b00, r_accum, 1'b0}
                   + {6'd0, i_byte[3:0]};
        w_acc_next = (w_acc_sum > PWM_W'(LEVEL_MAX)) ? ACCUM_SAT : w_acc_sum[ACCUM_W-1:0];
    end

    always_comb begin
        n_count  = r_count;
        n_phase  = r_phase;
        n_accum  = r_accum;
        n_neg    = r_neg;
        n_saw    = r_saw;
        n_level  = r_level;
        n_lit    = r_lit;
        w_status = ST_NONE;
        if (i_op == OP_BUTTON) begin
            n_lit = ~r_lit;
        end else if ((i_byte == CH_LF) || (i_byte == CH_CR)) begin
            if (r_count == '0) begin
                w_status = ST_NONE;
            end else if ((r_phase == PH_FIRST) || (r_phase == PH_EQ) ||
                         (r_phase == PH_BADCMD)) begin
                w_status = ST_BADCMD;
            end else if (r_saw && (r_accum <= LEVEL_MAX) &&
                         ((r_accum == '0) || !r_neg)) begin
                w_status = ST_SET;
                n_level  = r_accum;
            end else begin
                w_status = ST_BADVAL;
            end
            n_count = '0;
            n_phase = PH_FIRST;
            n_accum = '0;
            n_neg   = 1'b0;
            n_saw   = 1'b0;
        end else if (r_count >= COUNT_LAST) begin
            w_status = ST_TOOLONG;
            n_count  = '0;
            n_phase  = PH_FIRST;
            n_accum  = '0;
            n_neg    = 1'b0;
            n_saw    = 1'b0;
        end else begin
            n_count = r_count + 1'b1;
            if (i_byte == CH_NUL) begin
                if ((r_phase == PH_FIRST) || (r_phase == PH_EQ)) begin
                    n_phase = PH_BADCMD;
                end else if (r_phase != PH_BADCMD) begin
                    n_phase = PH_DONE;
                end
            end else begin
                case (r_phase)
                    PH_FIRST: begin
                        n_phase = ((i_byte == CH_LOW_L) || (i_byte == CH_UP_L)) ?
                                  PH_EQ : PH_BADCMD;
                    end
                    PH_EQ: begin
                        n_phase = (i_byte == CH_EQ) ? PH_WS : PH_BADCMD;
                    end
                    PH_WS: begin
                        if (w_is_ws) begin
                            n_phase = PH_WS;
                        end else if (i_byte == CH_PLUS) begin
                            n_phase = PH_SIGN;
                        end else if (i_byte == CH_MINUS) begin
                            n_neg   = 1'b1;
                            n_phase = PH_SIGN;
                        end else if (w_is_digit) begin
                            n_accum = w_acc_next;
                            n_saw   = 1'b1;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_SIGN, PH_DIGITS: begin
                        if (w_is_digit) begin
                            n_accum = w_acc_next;
                            n_saw   = 1'b1;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= PH_FIRST;
            r_accum <= '0;
            r_neg   <= 1'b0;
            r_saw   <= 1'b0;
            r_level <= LEVEL_RESET;
            r_lit   <= 1'b1;
        end else if (i_step) begin
            r_count <= n_count;
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_neg   <= n_neg;
            r_saw   <= n_saw;
            r_level <= n_level;
            r_lit   <= n_lit;
        end
    end

    always_comb begin
        o_result.status      = w_status;
        o_result.level       = n_level;
        o_result.lit         = n_lit;
        o_result.pwm_compare = n_lit ? ({n_level, 3'b000} + {2'b00, n_level, 1'b0})
                                     : '0;
    end

`ifndef SYNTHESIS
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LEVEL_MAX)
        else $error("Brightness register left the range 0 to 99.");

    a_accum_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_accum <= ACCUM_SAT)
        else $error("Value accumulator passed its saturation point.");

    a_button_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_op == OP_BUTTON)) |=> (r_lit != $past(r_lit)) &&
                                           (r_count == $past(r_count)))
        else $error("Button beat did not toggle the LED or disturbed the line.");

    a_digit_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_saw |-> ((r_phase == PH_DIGITS) || (r_phase == PH_DONE)))
        else $error("Digit flag set outside the digit or done phases.");
`endif

endmodule

`default_nettype wire

@@ rtl/uart_dimmer_command_parser_core.sv @@
// Channel  Direction  Payload                             Handshake
// i_cmd    in         op, rx_byte                         valid / ready
// o_res    out        status, level, pwm_compare, lit     valid / ready
//
// One result beat per input beat; a beat passes through the input register, then the result register.
// Full rate: a new beat is accepted every cycle while the result register drains.
// The input register holds a beat while the result register is full and stalled.
// Synchronous active-low reset: brightness 50, LED on, line parser empty.
// The only loop is the parser state update between the two registers.

`default_nettype none

module uart_dimmer_command_parser_core #(
    parameter int LINE_CAPACITY = udcp_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    udcp_in_if.sink     i_cmd,
    udcp_out_if.source  o_res
);
    import udcp_pkg::*;

    logic              r_in_valid;
    logic              r_in_op;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           w_result;
    logic              w_step;

    assign w_step      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_in_op   <= i_cmd.op;
            r_in_byte <= i_cmd.rx_byte;
        end
    end

    udcp_parser #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_op     (r_in_op),
        .i_byte   (r_in_byte),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out.status;
    assign o_res.level       = r_out.level;
    assign o_res.pwm_compare = r_out.pwm_compare;
    assign o_res.lit         = r_out.lit;

endmodule

`default_nettype wire
